// ----- hw/rtl/bloom_filter_four_hash_defines.svh -----
// ----------------------------------------------------------------------------
// Bloom filter assertion macros
// Shared assertion helpers for the Bloom filter modules. Each expects clk_i
// and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_FOUR_HASH_DEFINES_SVH
`define BLOOM_FILTER_FOUR_HASH_DEFINES_SVH

`ifndef SYNTHESIS
`define BFF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bloom filter check failed");
`define BFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bloom filter check failed");
`else
`define BFF_ASSERT_IMP(lbl, ante, cons)
`define BFF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/bff_pkg.sv -----
// ----------------------------------------------------------------------------
// Bloom filter package
// Types, constants and modular arithmetic helpers shared by the filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bff_pkg;

  localparam int unsigned ModW      = 8;
  localparam int unsigned NumHash   = 4;
  localparam int unsigned NumWeight = 3;
  localparam int unsigned NumLane   = 7;

  typedef logic [ModW-1:0] mod_t;

  localparam mod_t TableSizeReset = mod_t'(100);

  // Index 0 belongs to the second hash, index 2 to the fourth.
  localparam logic [NumWeight-1:0][ModW-1:0] WeightMul  = {8'd21, 8'd30, 8'd19};
  localparam logic [NumWeight-1:0][ModW-1:0] HashOffset = {8'd3, 8'd7, 8'd1};

  localparam logic [2:0] MulStartStep = 3'd7;
  localparam logic [2:0] FinStartStep = 3'd2;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                     is_query;
    mod_t [NumHash-1:0]       idx;
  } job_t;

  function automatic mod_t mod_add(mod_t a, mod_t b, mod_t m);
    logic [ModW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[ModW-1:0];
  endfunction

  function automatic mod_t mod_step(mod_t acc, logic bit_in, mod_t y, mod_t m);
    mod_t dbl;
    mod_t add;
    dbl = mod_add(acc, acc, m);
    add = bit_in ? y : '0;
    return mod_add(dbl, add, m);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bff_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bff_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bff_job_fifo.sv -----
// ----------------------------------------------------------------------------
// Bloom filter job queue
// Two-entry queue of finished hash index sets between the hash front end and
// the bit store sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bff_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  bff_pkg::job_t wr_job_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output bff_pkg::job_t rd_job_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  bff_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            push;
  logic            pop;

  assign wr_ready_o = (count_q != (PtrW+1)'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_job_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bff_front.sv -----
// ----------------------------------------------------------------------------
// Bloom filter hash front end
// Accepts key bytes and updates the four running hashes with seven modular
// multiply lanes that work one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bloom_filter_four_hash_defines.svh"

module bff_front #(
  parameter int unsigned MAX_BITS = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                store_ready_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_cmd_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output bff_pkg::job_t       job_o
);

  localparam bff_pkg::mod_t ModCap = bff_pkg::mod_t'((MAX_BITS > 255) ? 255 : MAX_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN,
    ST_PUSH
  } state_e;

  state_e            state_q;
  logic [2:0]        step_q;
  bff_pkg::mod_t     table_size_q;
  bff_pkg::mod_t     byte_q;
  logic              last_q;
  bff_pkg::cmd_e     cmd_q;
  bff_pkg::mod_t     sum_q  [bff_pkg::NumHash];
  bff_pkg::mod_t     w_q    [bff_pkg::NumWeight];
  bff_pkg::mod_t     acc_q  [bff_pkg::NumLane];
  bff_pkg::job_t     job_q;

  bff_pkg::mod_t     m;
  bff_pkg::mod_t     one;
  bff_pkg::mod_t     cfg_one;
  bff_pkg::mod_t     x_lane    [bff_pkg::NumLane];
  bff_pkg::mod_t     y_lane    [bff_pkg::NumLane];
  bff_pkg::mod_t     z_lane    [bff_pkg::NumLane];
  bff_pkg::mod_t     step_lane [bff_pkg::NumLane];
  bff_pkg::mod_t     res_lane  [bff_pkg::NumLane];

  always_comb begin
    if (table_size_q == '0) begin
      m = bff_pkg::mod_t'(1);
    end else if (table_size_q > ModCap) begin
      m = ModCap;
    end else begin
      m = table_size_q;
    end
    one     = (m == bff_pkg::mod_t'(1)) ? '0 : bff_pkg::mod_t'(1);
    cfg_one = (cfg_wdata_i <= 8'd1) ? '0 : bff_pkg::mod_t'(1);
  end

  always_comb begin
    for (int l = 0; l < bff_pkg::NumLane; l++) begin
      x_lane[l] = '0;
      y_lane[l] = one;
      z_lane[l] = '0;
    end
    if (state_q == ST_FIN) begin
      for (int k = 0; k < bff_pkg::NumWeight; k++) begin
        x_lane[k+1] = bff_pkg::HashOffset[k];
        z_lane[k+1] = sum_q[k+1];
      end
    end else begin
      x_lane[0] = byte_q;
      z_lane[0] = sum_q[0];
      for (int k = 0; k < bff_pkg::NumWeight; k++) begin
        x_lane[k+1] = byte_q;
        y_lane[k+1] = w_q[k];
        z_lane[k+1] = sum_q[k+1];
        x_lane[k+4] = bff_pkg::WeightMul[k];
        y_lane[k+4] = w_q[k];
      end
    end
    for (int l = 0; l < bff_pkg::NumLane; l++) begin
      step_lane[l] = bff_pkg::mod_step(acc_q[l], x_lane[l][step_q], y_lane[l], m);
      res_lane[l]  = bff_pkg::mod_add(step_lane[l], z_lane[l], m);
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE) && store_ready_i;
  assign job_valid_o = (state_q == ST_PUSH);
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      table_size_q <= bff_pkg::TableSizeReset;
      byte_q       <= '0;
      last_q       <= 1'b0;
      cmd_q        <= bff_pkg::CMD_INSERT;
      sum_q        <= '{default: '0};
      w_q          <= '{default: bff_pkg::mod_t'(1)};
      acc_q        <= '{default: '0};
      job_q        <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            byte_q  <= in_byte_i;
            last_q  <= in_last_i;
            cmd_q   <= bff_pkg::cmd_e'(in_cmd_i);
            acc_q   <= '{default: '0};
            step_q  <= bff_pkg::MulStartStep;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_q  <= step_lane;
          step_q <= step_q - 3'd1;
          if (step_q == '0) begin
            for (int h = 0; h < bff_pkg::NumHash; h++) begin
              sum_q[h] <= res_lane[h];
            end
            for (int k = 0; k < bff_pkg::NumWeight; k++) begin
              w_q[k] <= res_lane[k+4];
            end
            if (last_q) begin
              acc_q   <= '{default: '0};
              step_q  <= bff_pkg::FinStartStep;
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_FIN: begin
          acc_q  <= step_lane;
          step_q <= step_q - 3'd1;
          if (step_q == '0) begin
            job_q.is_query <= (cmd_q == bff_pkg::CMD_QUERY);
            job_q.idx[0]   <= sum_q[0];
            for (int k = 0; k < bff_pkg::NumWeight; k++) begin
              job_q.idx[k+1] <= res_lane[k+1];
            end
            sum_q   <= '{default: '0};
            w_q     <= '{default: one};
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (job_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cfg_we_i) begin
        table_size_q <= cfg_wdata_i;
        sum_q        <= '{default: '0};
        w_q          <= '{default: cfg_one};
      end
    end
  end

  `BFF_ASSERT_IMP(a_sums_below_modulus, state_q == ST_IDLE, (sum_q[0] < m) && (sum_q[1] < m) && (sum_q[2] < m) && (sum_q[3] < m))
  `BFF_ASSERT_IMP(a_job_idx_below_modulus, job_valid_o, (job_q.idx[0] < m) && (job_q.idx[1] < m) && (job_q.idx[2] < m) && (job_q.idx[3] < m))
  `BFF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

endmodule

`default_nettype wire

// ----- hw/rtl/bff_back.sv -----
// ----------------------------------------------------------------------------
// Bloom filter bit store sequencer
// Clears the bit store after reset, then sets or tests the four indexes of
// each job one per cycle and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bloom_filter_four_hash_defines.svh"

module bff_back #(
  parameter int unsigned MAX_BITS = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          store_ready_o,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  bff_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          out_hit_o,
  output logic          out_ins_o
);

  localparam int unsigned StoreDepth = (MAX_BITS > 256) ? 256 : MAX_BITS;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned HashW      = $clog2(bff_pkg::NumHash);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_LAST,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] clr_addr_q;
  bff_pkg::job_t    job_q;
  logic [HashW-1:0] k_q;
  logic             all_set_q;
  logic             rd_pend_q;
  logic             out_valid_q;
  logic             out_hit_q;
  logic             out_ins_q;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic             ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] cur_addr;
  logic             ram_rdata;
  logic             hit_now;

  assign cur_addr  = job_q.idx[k_q][AddrW-1:0];
  assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_RUN) && !job_q.is_query);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : cur_addr;
  assign ram_wdata = (state_q != ST_CLEAR);
  assign ram_re    = (state_q == ST_RUN) && job_q.is_query;
  assign hit_now   = all_set_q && (!rd_pend_q || ram_rdata);

  assign store_ready_o = (state_q != ST_CLEAR);
  assign job_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_hit_o     = out_hit_q;
  assign out_ins_o     = out_ins_q;

  bff_ram #(
    .WIDTH (1),
    .DEPTH (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      job_q       <= '0;
      k_q         <= '0;
      all_set_q   <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_ins_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + AddrW'(1);
          if (clr_addr_q == AddrW'(StoreDepth - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q     <= job_i;
            k_q       <= '0;
            all_set_q <= 1'b1;
            rd_pend_q <= 1'b0;
            state_q   <= ST_RUN;
          end
        end
        ST_RUN: begin
          k_q       <= k_q + HashW'(1);
          rd_pend_q <= job_q.is_query;
          all_set_q <= hit_now;
          if (k_q == HashW'(bff_pkg::NumHash - 1)) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          all_set_q <= hit_now;
          rd_pend_q <= 1'b0;
          state_q   <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= job_q.is_query && all_set_q;
            out_ins_q   <= !job_q.is_query;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `BFF_ASSERT_IMP(a_insert_never_hits, out_valid_o && out_ins_o, !out_hit_o)
  `BFF_ASSERT_IMP(a_no_job_while_clearing, state_q == ST_CLEAR, !job_ready_o && !store_ready_o)
  `BFF_ASSERT_IMP(a_read_only_for_query, rd_pend_q, job_q.is_query)

endmodule

`default_nettype wire

// ----- hw/rtl/bloom_filter_four_hash.sv -----
// ----------------------------------------------------------------------------
// Bloom filter with four hashes
// Top level: hash front end, job queue and bit store sequencer.
// ----------------------------------------------------------------------------
// Keys stream in one byte per transfer, and the byte with tlast closes the key
// and yields one result transfer. Each byte is taken by the hash front end and
// then run through the seven bit-serial modular multiply lanes, which step
// through the byte one bit per cycle. The closing byte then forms the offset
// hashes and hands the index set to the queue. The bit store sequencer makes
// one store port access per index of each key, and runs alongside the next
// key's bytes. After reset the bit store is cleared one entry per cycle, all
// min(MAX_BITS, 256) entries, with tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_four_hash #(
  parameter int unsigned MAX_BITS = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,    // table_size
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // key_byte
  input  logic       s_axis_tlast,
  input  logic       s_axis_tuser,   // cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // maybe_present, then zero fill
  output logic       m_axis_tuser    // was_insert
);

  logic          store_ready;
  logic          fe_job_valid;
  logic          fe_job_ready;
  bff_pkg::job_t fe_job;
  logic          be_job_valid;
  logic          be_job_ready;
  bff_pkg::job_t be_job;
  logic          out_hit;

  bff_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .store_ready_i (store_ready),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tuser),
    .in_byte_i     (s_axis_tdata),
    .in_last_i     (s_axis_tlast),
    .job_valid_o   (fe_job_valid),
    .job_ready_i   (fe_job_ready),
    .job_o         (fe_job)
  );

  bff_job_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_job_valid),
    .wr_ready_o (fe_job_ready),
    .wr_job_i   (fe_job),
    .rd_valid_o (be_job_valid),
    .rd_ready_i (be_job_ready),
    .rd_job_o   (be_job)
  );

  bff_back #(
    .MAX_BITS (MAX_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .store_ready_o (store_ready),
    .job_valid_i   (be_job_valid),
    .job_ready_o   (be_job_ready),
    .job_i         (be_job),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_hit_o     (out_hit),
    .out_ins_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0, out_hit};

endmodule

`default_nettype wire
